FILE: src/snm_pkg.sv
// Shared constants, types and tables of the square and noise sound mixer.
`default_nettype none

package snm_pkg;

  // Channel set: tone channels first, the noise channel at the last index
  localparam int TONE_CHANNELS = 3;
  localparam int MAX_VOLUME    = 15;
  localparam int NUM_CH        = TONE_CHANNELS + 1;
  localparam int CH_IDX_W      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int VOL_W         = $clog2(MAX_VOLUME + 1);

  // Field and datapath widths
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 2;
  localparam int HZ_W     = 16;
  localparam int PHASE_W  = 32;
  localparam int LFSR_W   = 16;
  localparam int LEVEL_W  = 8;

  localparam int unsigned SAMPLE_RATE_HZ   = 22050;
  localparam int unsigned NOISE_DEFAULT_HZ = 4000;
  localparam logic [LFSR_W-1:0] NOISE_TAPS = 16'hB800;
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'h0001;
  localparam int RESET_BIT_POS              = 7;
  localparam int unsigned FULL_LEVEL        = 255;

  // Phase step for the noise default frequency
  localparam logic [PHASE_W-1:0] NOISE_DEFAULT_STEP =
    PHASE_W'((64'(NOISE_DEFAULT_HZ) << PHASE_W) / 64'(SAMPLE_RATE_HZ));

  // Phase step hz * 2^32 / SAMPLE_RATE_HZ: a whole part per hertz plus the
  // remainder fraction taken by a reciprocal, exact for every 16-bit hz
  localparam longint unsigned PHASE_ONE      = 64'd1 << PHASE_W;
  localparam longint unsigned STEP_INT_VAL   = PHASE_ONE / 64'(SAMPLE_RATE_HZ);
  localparam longint unsigned STEP_REM_VAL   = PHASE_ONE % 64'(SAMPLE_RATE_HZ);
  localparam int              STEP_SH        = HZ_W + $clog2(SAMPLE_RATE_HZ);
  localparam longint unsigned STEP_RECIP_VAL =
    ((STEP_REM_VAL << STEP_SH) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ);
  localparam int STEP_INT_W   = $clog2(STEP_INT_VAL + 1);
  localparam int STEP_RECIP_W = $clog2(STEP_RECIP_VAL + 1);
  localparam int STEP_FRAC_W  = HZ_W + STEP_RECIP_W - STEP_SH;
  localparam logic [STEP_INT_W-1:0]   STEP_INT   = STEP_INT_W'(STEP_INT_VAL);
  localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = STEP_RECIP_W'(STEP_RECIP_VAL);

  // Mix: sum of all channel levels divided by NUM_CH through a reciprocal
  localparam int SUM_W     = $clog2(NUM_CH * FULL_LEVEL + 1);
  localparam int MIX_L     = $clog2(NUM_CH);
  localparam int MIX_K     = SUM_W + MIX_L;
  localparam int RECIP_W   = SUM_W + 1;
  localparam logic [RECIP_W-1:0] MIX_RECIP =
    RECIP_W'(((64'd1 << MIX_K) + 64'(NUM_CH) - 64'd1) / 64'(NUM_CH));

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_FREQ = 2'd1,
    KIND_VOL  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  // Level of a full-scale channel at each volume setting
  typedef logic [MAX_VOLUME:0][LEVEL_W-1:0] scale_tbl_t;

  function automatic scale_tbl_t build_scale_tbl();
    scale_tbl_t t;
    for (int v = 0; v <= MAX_VOLUME; v++) begin
      t[v] = LEVEL_W'((int'(FULL_LEVEL) * v) / MAX_VOLUME);
    end
    return t;
  endfunction

  localparam scale_tbl_t SCALE_TBL = build_scale_tbl();

endpackage

`default_nettype wire

FILE: src/snm_step_div.sv
// Two-stage reciprocal-multiply unit that turns a frequency into a 32-bit phase step.
`default_nettype none

module snm_step_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [snm_pkg::HZ_W-1:0]    hz,
  output logic                             done,
  output logic [snm_pkg::PHASE_W-1:0]      step
);
  import snm_pkg::*;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [PHASE_W-1:0]            base_r, base_nxt;
  logic [STEP_FRAC_W-1:0]        frac_r, frac_nxt;
  logic [PHASE_W-1:0]            step_r, step_nxt;
  logic [HZ_W+STEP_INT_W-1:0]    int_prod;
  logic [HZ_W+STEP_RECIP_W-1:0]  frac_prod;

  always_comb begin
    // whole steps per hertz, and the remainder fraction by reciprocal
    int_prod  = (HZ_W+STEP_INT_W)'(hz) * (HZ_W+STEP_INT_W)'(STEP_INT);
    frac_prod = (HZ_W+STEP_RECIP_W)'(hz) * (HZ_W+STEP_RECIP_W)'(STEP_RECIP);
    busy_nxt  = 1'b0;
    done_nxt  = 1'b0;
    base_nxt  = base_r;
    frac_nxt  = frac_r;
    step_nxt  = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      base_nxt = PHASE_W'(int_prod);
      frac_nxt = frac_prod[HZ_W+STEP_RECIP_W-1:STEP_SH];
    end else if (busy_r) begin
      // wrap to 32 bits
      step_nxt = base_r + PHASE_W'(frac_r);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    base_r <= base_nxt;
    frac_r <= frac_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign step = step_r;

endmodule

`default_nettype wire

FILE: src/square_and_noise_sound_mixer_top.sv
// Top level of the square-wave and noise sound mixer.
//
//  Channel | Ports                                    | Direction | Carries
//  --------+------------------------------------------+-----------+---------------------------
//  in      | in_valid in_ready in_kind in_channel     | input     | tick, frequency or volume
//          | in_value                                 |           | write item
//  out     | out_valid out_ready out_level            | output    | one mixed level per tick
//
// A sample tick walks the channels one per cycle through a shared 32-bit phase
// adder and then mixes them in the mix state. A frequency write runs the
// two-stage reciprocal step unit; a volume write is applied when accepted.
// Reset is synchronous and clears all channel state; the noise register starts at 1.
// A result waits in the output register while the next item is accepted; a tick
// that finishes while that result is still unclaimed holds in its mix cycle.
`default_nettype none

module square_and_noise_sound_mixer_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [snm_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [snm_pkg::CHAN_W-1:0]   in_channel,
  input  wire logic [snm_pkg::HZ_W-1:0]     in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [snm_pkg::LEVEL_W-1:0]       out_level
);
  import snm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_MIX,
    S_DIV
  } state_t;

  localparam logic [CH_IDX_W-1:0] NOISE_IDX = CH_IDX_W'(TONE_CHANNELS);
  localparam logic [CH_IDX_W-1:0] LAST_IDX  = CH_IDX_W'(NUM_CH - 1);

  state_t               state_r, state_nxt;
  logic [PHASE_W-1:0]   phase_r [NUM_CH];
  logic [PHASE_W-1:0]   phase_nxt [NUM_CH];
  logic [PHASE_W-1:0]   step_r [NUM_CH];
  logic [PHASE_W-1:0]   step_nxt [NUM_CH];
  logic [VOL_W-1:0]     vol_r [NUM_CH];
  logic [VOL_W-1:0]     vol_nxt [NUM_CH];
  logic [LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [CH_IDX_W-1:0]  idx_r, idx_nxt;
  logic [CH_IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;

  logic                 accept;
  logic                 ch_ok;
  logic [CH_IDX_W-1:0]  wr_idx;
  logic [VOL_W-1:0]     vol_clamp;
  logic                 div_start;
  logic                 div_done;
  logic [PHASE_W-1:0]   div_step;

  logic [PHASE_W-1:0]   cur_phase, cur_step;
  logic [VOL_W-1:0]     cur_vol;
  logic [PHASE_W:0]     phase_sum;
  logic                 active, is_noise, wave_bit;
  logic [LFSR_W-1:0]    lfsr_shift;
  logic [LEVEL_W-1:0]   contrib;
  logic [2*SUM_W:0]     mix_prod;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ch_ok     = (int'(in_channel) <= TONE_CHANNELS);
  assign wr_idx    = CH_IDX_W'(in_channel);
  assign vol_clamp = (in_value[7:0] > 8'(MAX_VOLUME)) ? VOL_W'(MAX_VOLUME)
                                                      : VOL_W'(in_value[7:0]);
  assign div_start = accept && (kind_t'(in_kind) == KIND_FREQ) && ch_ok;

  snm_step_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .hz    (in_value),
    .done  (div_done),
    .step  (div_step)
  );

  // Shared channel datapath: one channel per cycle at idx_r
  always_comb begin
    cur_phase  = phase_r[idx_r];
    cur_step   = step_r[idx_r];
    cur_vol    = vol_r[idx_r];
    phase_sum  = {1'b0, cur_phase} + {1'b0, cur_step};
    active     = (cur_vol != '0) && (cur_step != '0);
    is_noise   = (idx_r == NOISE_IDX);
    lfsr_shift = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? NOISE_TAPS : '0);
    mix_prod   = sum_r * MIX_RECIP;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    vol_nxt       = vol_r;
    lfsr_nxt      = lfsr_r;
    idx_nxt       = idx_r;
    wr_idx_nxt    = wr_idx_r;
    sum_nxt       = sum_r;
    level_nxt     = level_r;
    wave_bit      = 1'b0;
    contrib       = '0;
    // drop the pending result once taken
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(in_kind))
            KIND_TICK: begin
              idx_nxt   = '0;
              sum_nxt   = '0;
              state_nxt = S_TICK;
            end
            KIND_FREQ: begin
              if (ch_ok) begin
                wr_idx_nxt = wr_idx;
                state_nxt  = S_DIV;
              end
            end
            KIND_VOL: begin
              if (ch_ok) begin
                vol_nxt[wr_idx] = vol_clamp;
                if (wr_idx == NOISE_IDX) begin
                  if ((vol_clamp != '0) && (step_r[NOISE_IDX] == '0)) begin
                    step_nxt[NOISE_IDX] = NOISE_DEFAULT_STEP;
                  end
                  if (in_value[RESET_BIT_POS]) begin
                    phase_nxt[NOISE_IDX] = '0;
                    lfsr_nxt             = LFSR_SEED;
                  end
                end
              end
            end
            KIND_RSVD: begin
            end
          endcase
        end
      end

      S_TICK: begin
        // advance the active channel; noise clocks its register on carry out
        if (active) begin
          phase_nxt[idx_r] = phase_sum[PHASE_W-1:0];
          if (is_noise && phase_sum[PHASE_W]) begin
            lfsr_nxt = lfsr_shift;
          end
        end
        wave_bit = is_noise ? lfsr_nxt[0] : phase_sum[PHASE_W-1];
        contrib  = (active && wave_bit) ? SCALE_TBL[cur_vol] : '0;
        sum_nxt  = sum_r + SUM_W'(contrib);
        if (idx_r == LAST_IDX) begin
          state_nxt = S_MIX;
        end else begin
          idx_nxt = idx_r + CH_IDX_W'(1);
        end
      end

      S_MIX: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          level_nxt     = LEVEL_W'(mix_prod >> MIX_K);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          step_nxt[wr_idx_r] = div_step;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      for (int i = 0; i < NUM_CH; i++) begin
        phase_r[i] <= '0;
        step_r[i]  <= '0;
        vol_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lfsr_r      <= lfsr_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      vol_r       <= vol_nxt;
    end
    idx_r    <= idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    sum_r    <= sum_nxt;
    level_r  <= level_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_level = level_r;

  // A tick item keeps the input closed on the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (kind_t'(in_kind) == KIND_TICK)) |=> !in_ready)
    else $error("input reopened right after a tick item");

  // Divider completion only lands while a frequency write waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside a frequency write");

  // The noise register never locks up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise register reached zero");

  // A new result only comes out of the mix cycle
  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && !out_ready)) |-> ($past(state_r) == S_MIX))
    else $error("result loaded outside the mix cycle");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for the square and noise sound mixer: directed and random items checked by a scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import snm_pkg::*;

  // Run shape: random items (not counting ignored ones) split into idling phases
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASES       = 8;
  // Ceiling on the whole run; the slowest correct run stays far below it
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Cycles to let pass after the last level: covers the frequency step unit
  localparam int SETTLE_CYCLES = 64;
  localparam int RESET_CYCLES  = 12;

  // Mixer state mirror: predicts one level per tick and keeps the levels still owed
  class mix_level_scoreboard;
    logic [PHASE_W-1:0] tone_phase [TONE_CHANNELS];
    logic [PHASE_W-1:0] tone_step  [TONE_CHANNELS];
    logic [VOL_W-1:0]   tone_vol   [TONE_CHANNELS];
    logic [PHASE_W-1:0] noise_phase;
    logic [PHASE_W-1:0] noise_step;
    logic [VOL_W-1:0]   noise_vol;
    logic [LFSR_W-1:0]  noise_lfsr;
    logic [LEVEL_W-1:0] expected_levels [$];
    int ticks, freq_writes, vol_writes, ignored, checked, errors;

    function new();
      for (int i = 0; i < TONE_CHANNELS; i++) begin
        tone_phase[i] = '0;
        tone_step[i]  = '0;
        tone_vol[i]   = '0;
      end
      noise_phase = '0;
      noise_step  = '0;
      noise_vol   = '0;
      noise_lfsr  = LFSR_SEED;
    endfunction

    function logic [PHASE_W-1:0] hz_to_step(logic [HZ_W-1:0] hz);
      logic [63:0] num;
      num = 64'(hz) << PHASE_W;
      return PHASE_W'(num / 64'(SAMPLE_RATE_HZ));
    endfunction

    function int unsigned scaled_level(logic on, logic [VOL_W-1:0] vol);
      return on ? (FULL_LEVEL * int'(vol)) / MAX_VOLUME : 0;
    endfunction

    // Advance every active channel by one sample and average them
    function logic [LEVEL_W-1:0] mix_tick();
      int unsigned sum;
      logic [PHASE_W:0] acc;
      sum = 0;
      for (int i = 0; i < TONE_CHANNELS; i++) begin
        if (tone_vol[i] != 0 && tone_step[i] != 0) begin
          tone_phase[i] = tone_phase[i] + tone_step[i];
          sum += scaled_level(tone_phase[i][PHASE_W-1], tone_vol[i]);
        end
      end
      if (noise_vol != 0 && noise_step != 0) begin
        acc = {1'b0, noise_phase} + {1'b0, noise_step};
        noise_phase = acc[PHASE_W-1:0];
        if (acc[PHASE_W])
          noise_lfsr = noise_lfsr[0] ? ((noise_lfsr >> 1) ^ NOISE_TAPS) : (noise_lfsr >> 1);
        sum += scaled_level(noise_lfsr[0], noise_vol);
      end
      return LEVEL_W'(sum / NUM_CH);
    endfunction

    function void note_item(kind_t kind, logic [CHAN_W-1:0] ch, logic [HZ_W-1:0] value);
      logic [7:0] raw;
      logic [VOL_W-1:0] vol;
      raw = value[7:0];
      vol = (raw > MAX_VOLUME) ? VOL_W'(MAX_VOLUME) : VOL_W'(raw);
      case (kind)
        KIND_TICK: begin
          ticks++;
          expected_levels.push_back(mix_tick());
        end
        KIND_FREQ: begin
          freq_writes++;
          if (ch < TONE_CHANNELS)
            tone_step[ch] = hz_to_step(value);
          else if (ch == TONE_CHANNELS)
            noise_step = hz_to_step(value);
        end
        KIND_VOL: begin
          vol_writes++;
          if (ch < TONE_CHANNELS) begin
            tone_vol[ch] = vol;
          end else if (ch == TONE_CHANNELS) begin
            noise_vol = vol;
            if (vol != 0 && noise_step == 0)
              noise_step = hz_to_step(HZ_W'(NOISE_DEFAULT_HZ));
            if (value[RESET_BIT_POS]) begin
              noise_phase = '0;
              noise_lfsr  = LFSR_SEED;
            end
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void check_level(logic [LEVEL_W-1:0] got);
      logic [LEVEL_W-1:0] want;
      if (expected_levels.size() == 0) begin
        $error("out_level: no level expected, actual %0d", got);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      if (got !== want) begin
        $error("out_level mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind    = KIND_TICK;
  logic [CHAN_W-1:0]   in_channel = '0;
  logic [HZ_W-1:0]     in_value   = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [LEVEL_W-1:0]  out_level;

  // Idling knobs in percent: sender gaps per cycle, receiver stalls per cycle
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  mix_level_scoreboard sb = new();

  square_and_noise_sound_mixer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_channel (in_channel),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop out_ready at random according to the current stall rate
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Note every accepted item in the predictor; handshake values are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_item(kind_t'(in_kind), in_channel, in_value);
  end

  // Check every accepted level against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_level(out_level);
  end

  // Count cycles and end a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Present one item after a random idle gap and hold it until accepted
  task automatic send_item(input kind_t kind, input logic [CHAN_W-1:0] ch,
                           input logic [HZ_W-1:0] value);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_channel <= ch;
    in_value   <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender off until every predicted level has been claimed
  task automatic wait_for_levels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    kind_t kind;
    logic [CHAN_W-1:0] ch;
    logic [HZ_W-1:0] value;
    int sent;
    int pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: silent start, extreme frequencies, volume clamping,
    // noise default step, noise restart bit, reserved kind, silencing
    send_item(KIND_TICK, 2'd0, 16'h0000);
    send_item(KIND_FREQ, 2'd0, 16'hFFFF);
    send_item(KIND_FREQ, 2'd1, 16'h0001);
    send_item(KIND_FREQ, 2'd2, 16'h0000);
    send_item(KIND_VOL,  2'd0, 16'h00FF);
    send_item(KIND_VOL,  2'd1, 16'hFF0F);
    send_item(KIND_VOL,  2'd2, 16'h0010);
    send_item(KIND_TICK, 2'd3, 16'hFFFF);
    send_item(KIND_VOL,  2'd3, 16'h0008);
    send_item(KIND_TICK, 2'd0, 16'h0000);
    send_item(KIND_TICK, 2'd1, 16'h5A5A);
    send_item(KIND_FREQ, 2'd3, 16'd11025);
    send_item(KIND_TICK, 2'd0, 16'h0000);
    send_item(KIND_TICK, 2'd0, 16'h0000);
    send_item(KIND_VOL,  2'd3, 16'h0085);
    send_item(KIND_TICK, 2'd2, 16'hA5A5);
    send_item(KIND_VOL,  2'd0, 16'h0080);
    send_item(KIND_RSVD, 2'd3, 16'hFFFF);
    send_item(KIND_FREQ, 2'd2, 16'd5512);
    send_item(KIND_TICK, 2'd0, 16'h0000);
    send_item(KIND_VOL,  2'd3, 16'h0000);
    send_item(KIND_TICK, 2'd0, 16'h0000);
    send_item(KIND_VOL,  2'd1, 16'h0000);
    send_item(KIND_TICK, 2'd0, 16'h0000);
    wait_for_levels();

    // Random part: cycle through the idling phases, draining after every odd-numbered phase
    sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      while (sent < (RANDOM_ITEMS * (phase + 1)) / PHASES) begin
        pick  = $urandom_range(99);
        ch    = CHAN_W'($urandom_range(3));
        value = HZ_W'($urandom);
        if (pick < 55) begin
          kind = KIND_TICK;
        end else if (pick < 65) begin
          kind = KIND_FREQ;
          // mostly audible tones, sometimes zero, full scale or any value
          case ($urandom_range(9))
            0: value = '0;
            1: value = '1;
            2: ;
            default: value = HZ_W'($urandom_range(5000, 20));
          endcase
        end else if (pick < 95) begin
          kind = KIND_VOL;
          // mostly in-range volumes; also raw bytes and the noise restart bit
          case ($urandom_range(7))
            0: ;
            1: value = {value[15:8], 1'b1, 7'($urandom_range(MAX_VOLUME))};
            2: value = {value[15:8], 8'($urandom_range(MAX_VOLUME))};
            default: value = HZ_W'($urandom_range(MAX_VOLUME));
          endcase
        end else begin
          kind = KIND_RSVD;
        end
        send_item(kind, ch, value);
        if (kind != KIND_RSVD)
          sent++;
      end
      if (phase % 2 == 1)
        wait_for_levels();
    end

    // Drain: release the receiver, wait for every level, then let the block settle
    stall_pct = 0;
    wait_for_levels();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("out_level: %0d expected levels never arrived", sb.pending());
      sb.errors++;
    end

    $display("Summary: %0d ticks, %0d frequency writes, %0d volume writes, %0d ignored items",
             sb.ticks, sb.freq_writes, sb.vol_writes, sb.ignored);
    $display("Summary: %0d levels compared, %0d errors, %0d cycles",
             sb.checked, sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/snm_pkg.sv
src/snm_step_div.sv
src/square_and_noise_sound_mixer_top.sv
bench/tb_top.sv
